/* sv/rbu_pkg.sv */
// Shared types and constants of the raw bitmap to BGRA unpacker.
package rbu_pkg;

    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int DEST_W     = 24;

    localparam logic [7:0] ALPHA_BYTE = 8'hFF;
    localparam logic [7:0] DEPTH_24   = 8'd24;
    localparam logic [7:0] DEPTH_32   = 8'd32;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_DATA  = 1'b1;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_PIXEL  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH,
        CFG_HEIGHT,
        CFG_BPP,
        CFG_BOTTOM_UP
    } t_cfg_idx;

    typedef enum logic [1:0] {
        STAT_OK,
        STAT_TOO_SMALL,
        STAT_BAD_DEPTH
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STRIDE,
        S_SIZE,
        S_BASE,
        S_REPORT
    } t_state;

    typedef enum logic [2:0] {
        CMD_IDLE,
        CMD_START,
        CMD_BYTE,
        CMD_MUL_STRIDE,
        CMD_MUL_SIZE,
        CMD_MUL_BASE,
        CMD_REPORT
    } t_cmd;

    typedef struct packed {
        logic              kind;
        logic [1:0]        status;
        logic [31:0]       pixel_bgra;
        logic [DEST_W-1:0] dest_index;
        logic              frame_done;
    } t_result;

endpackage

/* sv/rbu_in_if.sv */
// Input channel of the unpacker: frame starts and source bytes.
interface rbu_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] chunk_bytes;
    logic [7:0]  data_byte;

    modport source (output valid, func, chunk_bytes, data_byte, input ready);
    modport sink   (input valid, func, chunk_bytes, data_byte, output ready);
endinterface

/* sv/rbu_out_if.sv */
// Output channel of the unpacker: frame status and converted pixels.
interface rbu_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [1:0]  status;
    logic [31:0] pixel_bgra;
    logic [23:0] dest_index;
    logic        frame_done;

    modport source (output valid, kind, status, pixel_bgra, dest_index, frame_done,
                    input ready);
    modport sink   (input valid, kind, status, pixel_bgra, dest_index, frame_done,
                    output ready);
endinterface

/* sv/rbu_ctrl.sv */
// Controller: accepts transactions and sequences the frame-start size check.
module rbu_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_func,
    input  logic          i_q_full,
    output logic          o_in_ready,
    output rbu_pkg::t_cmd o_cmd
);
    import rbu_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = CMD_IDLE;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = !i_q_full;
                if (i_in_valid && !i_q_full) begin
                    if (i_in_func == FUNC_START) begin
                        o_cmd   = CMD_START;
                        n_state = S_STRIDE;
                    end else begin
                        o_cmd = CMD_BYTE;
                    end
                end
            end
            S_STRIDE: begin
                o_cmd   = CMD_MUL_STRIDE;
                n_state = S_SIZE;
            end
            S_SIZE: begin
                o_cmd   = CMD_MUL_SIZE;
                n_state = S_BASE;
            end
            S_BASE: begin
                o_cmd   = CMD_MUL_BASE;
                n_state = S_REPORT;
            end
            S_REPORT: begin
                o_cmd   = CMD_REPORT;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_start_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd == CMD_START) |-> ##4 (o_cmd == CMD_REPORT))
        else $error("frame start did not reach its status report");

endmodule

/* sv/rbu_dp.sv */
// Datapath: configuration, size check multiplier and the byte-to-pixel unpacker.
module rbu_dp #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rbu_pkg::t_cmd                    i_cmd,
    input  logic                             i_cfg_we,
    input  logic [rbu_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rbu_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [31:0]                      i_chunk_bytes,
    input  logic [7:0]                       i_data_byte,
    output logic                             o_push,
    output rbu_pkg::t_result                 o_result
);
    import rbu_pkg::*;

    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int RSW  = CW + 3;
    localparam int SW   = WW + 5;
    localparam int PW   = SW + HW;
    localparam int CMPW = (PW > 32) ? PW : 32;

    function automatic logic [WW-1:0] clamp_w(input logic [CFG_DATA_W-1:0] v);
        if (v == '0) begin
            return WW'(1);
        end else if (32'(v) > MAX_WIDTH) begin
            return WW'(MAX_WIDTH);
        end
        return WW'(v);
    endfunction

    function automatic logic [HW-1:0] clamp_h(input logic [CFG_DATA_W-1:0] v);
        if (v == '0) begin
            return HW'(1);
        end else if (32'(v) > MAX_HEIGHT) begin
            return HW'(MAX_HEIGHT);
        end
        return HW'(v);
    endfunction

    // Configuration, widths already clamped to their legal range.
    logic [WW-1:0]     r_w;
    logic [HW-1:0]     r_h;
    logic [7:0]        r_bpp;
    logic              r_bottom_up;

    // Frame-start working registers.
    logic [31:0]       r_chunk;
    logic [PW-1:0]     r_prod;
    logic [SW-1:0]     r_stride;
    logic [SW-1:0]     r_data_len;
    logic              r_too_small;

    // Unpacking state.
    logic              r_frame_active;
    logic [RSW-1:0]    r_byte_in_row;
    logic [1:0]        r_byte_in_pixel;
    logic [23:0]       r_pixel_asm;
    logic [RW-1:0]     r_src_row;
    logic [RSW-1:0]    r_row_stride;
    logic [CW-1:0]     r_col;
    logic [DEST_W-1:0] r_row_base;

    logic [SW-1:0]     mul_a;
    logic [HW-1:0]     mul_b;
    logic [PW-1:0]     mul_p;
    logic [SW-1:0]     stride_c;
    logic              depth_ok;
    logic              frame_ok;
    t_status           stat;
    logic              byte_go;
    logic              in_row;
    logic              emit;
    logic              row_last;
    logic              last;
    logic [RSW:0]      bir_next;
    logic              row_end;
    logic [23:0]       n_pixel_asm;
    logic [DEST_W-1:0] dest;

    assign stride_c = (r_prod[SW-1:0] + SW'(3)) & ~SW'(3);

    always_comb begin
        case (i_cmd)
            CMD_MUL_STRIDE: begin
                mul_a = SW'(r_w);
                mul_b = HW'(r_bpp[7:3]);
            end
            CMD_MUL_SIZE: begin
                mul_a = stride_c;
                mul_b = r_h;
            end
            CMD_MUL_BASE: begin
                mul_a = SW'(r_w);
                mul_b = r_h - HW'(1);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PW'(mul_a) * PW'(mul_b);

    assign depth_ok = (r_bpp == DEPTH_24) || (r_bpp == DEPTH_32);
    assign frame_ok = !r_too_small && depth_ok;

    always_comb begin
        if (r_too_small) begin
            stat = STAT_TOO_SMALL;
        end else if (!depth_ok) begin
            stat = STAT_BAD_DEPTH;
        end else begin
            stat = STAT_OK;
        end
    end

    assign byte_go  = (i_cmd == CMD_BYTE) && r_frame_active;
    assign in_row   = SW'(r_byte_in_row) < r_data_len;
    assign emit     = in_row && ((r_bpp == DEPTH_32) ? (r_byte_in_pixel == 2'd3)
                                                     : (r_byte_in_pixel >= 2'd2));
    assign row_last = (32'(r_src_row) + 32'd1) >= 32'(r_h);
    assign last     = emit && row_last && ((32'(r_col) + 32'd1) >= 32'(r_w));
    assign bir_next = {1'b0, r_byte_in_row} + (RSW + 1)'(1);
    assign row_end  = bir_next >= {1'b0, r_row_stride};
    assign dest     = r_row_base + DEST_W'(r_col);

    always_comb begin
        case (r_byte_in_pixel)
            2'd0:    n_pixel_asm = {r_pixel_asm[23:8], i_data_byte};
            2'd1:    n_pixel_asm = {r_pixel_asm[23:16], i_data_byte, r_pixel_asm[7:0]};
            2'd2:    n_pixel_asm = {i_data_byte, r_pixel_asm[15:0]};
            default: n_pixel_asm = r_pixel_asm;
        endcase
    end

    always_comb begin
        o_result = '0;
        o_push   = 1'b0;
        if (i_cmd == CMD_REPORT) begin
            o_push          = 1'b1;
            o_result.kind   = KIND_STATUS;
            o_result.status = stat;
        end else if (byte_go && emit) begin
            o_push              = 1'b1;
            o_result.kind       = KIND_PIXEL;
            o_result.pixel_bgra = {ALPHA_BYTE, n_pixel_asm};
            o_result.dest_index = dest;
            o_result.frame_done = last;
        end
    end

    // Payload registers of the frame-start sequence.
    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_START) begin
            r_chunk <= i_chunk_bytes;
        end
        if (i_cmd == CMD_MUL_STRIDE || i_cmd == CMD_MUL_SIZE || i_cmd == CMD_MUL_BASE) begin
            r_prod <= mul_p;
        end
        if (i_cmd == CMD_MUL_SIZE) begin
            r_stride   <= stride_c;
            r_data_len <= r_prod[SW-1:0];
        end
        if (i_cmd == CMD_MUL_BASE) begin
            r_too_small <= CMPW'(r_chunk) < CMPW'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w             <= clamp_w(CFG_DATA_W'(640));
            r_h             <= clamp_h(CFG_DATA_W'(480));
            r_bpp           <= DEPTH_24;
            r_bottom_up     <= 1'b1;
            r_frame_active  <= 1'b0;
            r_byte_in_row   <= '0;
            r_byte_in_pixel <= '0;
            r_pixel_asm     <= '0;
            r_src_row       <= '0;
            r_row_stride    <= '0;
            r_col           <= '0;
            r_row_base      <= '0;
        end else begin
            if (i_cmd == CMD_REPORT) begin
                r_frame_active  <= frame_ok;
                r_byte_in_row   <= '0;
                r_byte_in_pixel <= '0;
                r_pixel_asm     <= '0;
                r_src_row       <= '0;
                r_col           <= '0;
                r_row_stride    <= frame_ok ? r_stride[RSW-1:0] : '0;
                r_row_base      <= r_bottom_up ? DEST_W'(r_prod) : '0;
            end else if (byte_go) begin
                if (in_row) begin
                    if (emit) begin
                        r_pixel_asm     <= '0;
                        r_byte_in_pixel <= '0;
                        r_col           <= r_col + CW'(1);
                    end else begin
                        r_pixel_asm     <= n_pixel_asm;
                        r_byte_in_pixel <= r_byte_in_pixel + 2'd1;
                    end
                end
                if (last) begin
                    // The last pixel closes the frame; its row counters are left as they are.
                    r_frame_active <= 1'b0;
                end else if (row_end) begin
                    r_byte_in_row   <= '0;
                    r_byte_in_pixel <= '0;
                    r_pixel_asm     <= '0;
                    r_col           <= '0;
                    if (row_last) begin
                        r_frame_active <= 1'b0;
                        r_src_row      <= '0;
                    end else begin
                        r_src_row <= r_src_row + RW'(1);
                    end
                    if (r_bottom_up) begin
                        r_row_base <= r_row_base - DEST_W'(r_w);
                    end else begin
                        r_row_base <= r_row_base + DEST_W'(r_w);
                    end
                end else begin
                    r_byte_in_row <= bir_next[RSW-1:0];
                end
            end

            if (i_cfg_we) begin
                r_frame_active <= 1'b0;
                case (t_cfg_idx'(i_cfg_index))
                    CFG_WIDTH:     r_w         <= clamp_w(i_cfg_data);
                    CFG_HEIGHT:    r_h         <= clamp_h(i_cfg_data);
                    CFG_BPP:       r_bpp       <= i_cfg_data[7:0];
                    CFG_BOTTOM_UP: r_bottom_up <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    a_done_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_result.kind == KIND_PIXEL && o_result.frame_done && !i_cfg_we)
            |=> !r_frame_active)
        else $error("frame still active after its last pixel");

    a_pixel_needs_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_result.kind == KIND_PIXEL) |-> r_frame_active)
        else $error("pixel produced outside an active frame");

endmodule

/* sv/rbu_outq.sv */
// Two-entry result queue that decouples the unpacker from the output channel.
module rbu_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rbu_pkg::t_result i_data,
    input  logic             i_ready,
    output logic             o_valid,
    output rbu_pkg::t_result o_data,
    output logic             o_full
);
    import rbu_pkg::*;

    logic    r_head_valid;
    logic    r_tail_valid;
    t_result r_head;
    t_result r_tail;
    logic    pop;

    assign pop     = r_head_valid && i_ready;
    assign o_valid = r_head_valid;
    assign o_data  = r_head;
    assign o_full  = r_tail_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_tail_valid <= 1'b0;
        end else begin
            if (pop) begin
                if (r_tail_valid) begin
                    r_head       <= r_tail;
                    r_head_valid <= 1'b1;
                    r_tail_valid <= i_push;
                    if (i_push) begin
                        r_tail <= i_data;
                    end
                end else begin
                    r_head_valid <= i_push;
                    if (i_push) begin
                        r_head <= i_data;
                    end
                end
            end else if (i_push) begin
                if (r_head_valid) begin
                    r_tail       <= i_data;
                    r_tail_valid <= 1'b1;
                end else begin
                    r_head       <= i_data;
                    r_head_valid <= 1'b1;
                end
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!r_tail_valid || pop))
        else $error("result pushed into a full queue");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail_valid |-> r_head_valid)
        else $error("queue tail holds a result with an empty head");

endmodule

/* sv/raw_bitmap_to_bgra_unpack.sv */
// Raw bitmap unpacker: a frame-start transaction is checked against stride times
// height and the depth, then answered with one status result once the shared
// multiplier has formed the stride, the expected size and the base row for bottom-up
// images in turn; data-byte transactions are taken one per cycle while the controller
// is idle and the result queue is not full, and each finished 24- or 32-bit source
// pixel leaves as a BGRA pixel with alpha 0xFF and its destination index. A two-entry
// result queue lets the block take the next transaction while a result waits at the output.
module raw_bitmap_to_bgra_unpack #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rbu_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rbu_pkg::CFG_DATA_W-1:0] i_cfg_data,
    rbu_in_if.sink                         i_in_ch,
    rbu_out_if.source                      o_out_ch
);
    import rbu_pkg::*;

    t_cmd    cmd;
    logic    q_full;
    logic    push;
    t_result result;
    t_result q_data;
    logic    q_valid;

    rbu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_ch.valid),
        .i_in_func  (i_in_ch.func),
        .i_q_full   (q_full),
        .o_in_ready (i_in_ch.ready),
        .o_cmd      (cmd)
    );

    rbu_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_chunk_bytes (i_in_ch.chunk_bytes),
        .i_data_byte   (i_in_ch.data_byte),
        .o_push        (push),
        .o_result      (result)
    );

    rbu_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (result),
        .i_ready (o_out_ch.ready),
        .o_valid (q_valid),
        .o_data  (q_data),
        .o_full  (q_full)
    );

    assign o_out_ch.valid      = q_valid;
    assign o_out_ch.kind       = q_data.kind;
    assign o_out_ch.status     = q_data.status;
    assign o_out_ch.pixel_bgra = q_data.pixel_bgra;
    assign o_out_ch.dest_index = q_data.dest_index;
    assign o_out_ch.frame_done = q_data.frame_done;

endmodule

/* bench/raw_bitmap_to_bgra_unpack_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the raw bitmap to BGRA unpacker.
module raw_bitmap_to_bgra_unpack_tb;
    import rbu_pkg::*;

    localparam int MAX_W         = 4096;
    localparam int MAX_H         = 4096;
    localparam int LIMIT_CYCLES  = 1000000;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 200;
    localparam int RANDOM_ITEMS  = 750;
    localparam int MAX_REPORTS   = 200;

    typedef enum logic [1:0] {
        OP_CFG,
        OP_START,
        OP_BYTE
    } t_op;

    typedef struct packed {
        t_op         op;
        t_cfg_idx    reg_sel;
        logic [31:0] value;
        logic        fixed;
        t_status     status;
    } t_step;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    rbu_in_if  in_ch ();
    rbu_out_if out_ch ();

    raw_bitmap_to_bgra_unpack #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_ch     (in_ch),
        .o_out_ch    (out_ch)
    );

    // Shadow copy of the registers and of the frame walk.
    logic [12:0] cfg_width;
    logic [12:0] cfg_height;
    logic [7:0]  cfg_depth;
    logic        cfg_bottom_up;
    logic        frame_open;
    logic [14:0] row_pos;
    logic [1:0]  pix_pos;
    logic [23:0] pix_bytes;
    logic [12:0] row_num;
    logic [14:0] row_pitch;
    logic [11:0] col_num;

    t_result status_pixel_q [$];
    int      errors  = 0;
    int      cycles  = 0;
    int      counted = 0;
    bit      quiet   = 1'b0;
    bit      hold_req = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("[%0t] mismatch on %s: got 0x%0h, wanted 0x%0h", $time, what, got, want);
    endtask

    function automatic int unsigned eff_width();
        if (cfg_width == 0) return 1;
        if (cfg_width > MAX_W) return MAX_W;
        return 32'(cfg_width);
    endfunction

    function automatic int unsigned eff_height();
        if (cfg_height == 0) return 1;
        if (cfg_height > MAX_H) return MAX_H;
        return 32'(cfg_height);
    endfunction

    // The size check uses the whole bytes of the depth, even for depths that never convert.
    function automatic longint unsigned frame_pitch();
        longint unsigned p;
        p = eff_width() * (cfg_depth / 8);
        return (p + 3) & ~64'd3;
    endfunction

    function automatic longint unsigned expected_bytes();
        return frame_pitch() * eff_height();
    endfunction

    function automatic void write_shadow(t_cfg_idx sel, logic [12:0] val);
        case (sel)
            CFG_WIDTH:  cfg_width = val;
            CFG_HEIGHT: cfg_height = val;
            CFG_BPP:    cfg_depth = val[7:0];
            default:    cfg_bottom_up = val[0];
        endcase
        frame_open = 1'b0;
    endfunction

    function automatic bit convert_item(input logic func, input logic [31:0] chunk,
                                        input logic [7:0] data, output t_result res);
        int unsigned     w;
        int unsigned     h;
        int unsigned     bpb;
        int unsigned     dlen;
        int unsigned     drow;
        logic [31:0]     idx;
        longint unsigned need;
        bit              has;
        bit              last;
        t_status         st;
        w    = eff_width();
        h    = eff_height();
        res  = '0;
        has  = 1'b0;
        if (func == FUNC_START) begin
            need = expected_bytes();
            if (chunk < need)
                st = STAT_TOO_SMALL;
            else if (cfg_depth != DEPTH_24 && cfg_depth != DEPTH_32)
                st = STAT_BAD_DEPTH;
            else
                st = STAT_OK;
            frame_open = (st == STAT_OK);
            row_pos    = '0;
            pix_pos    = '0;
            pix_bytes  = '0;
            row_num    = '0;
            col_num    = '0;
            row_pitch  = frame_open ? 15'(frame_pitch()) : '0;
            res.kind   = KIND_STATUS;
            res.status = st;
            return 1'b1;
        end
        if (!frame_open) return 1'b0;
        bpb  = (cfg_depth == DEPTH_32) ? 4 : 3;
        dlen = w * bpb;
        if (row_pos < dlen) begin
            if (pix_pos < 3) pix_bytes[{pix_pos, 3'b000} +: 8] = data;
            if (pix_pos + 1 >= bpb) begin
                drow = cfg_bottom_up ? h - 1 - row_num : row_num;
                idx  = drow * w + col_num;
                last = (row_num + 1 >= h) && (col_num + 1 >= w);
                res.kind       = KIND_PIXEL;
                res.pixel_bgra = {ALPHA_BYTE, pix_bytes};
                res.dest_index = idx[DEST_W-1:0];
                res.frame_done = last;
                has            = 1'b1;
                pix_bytes      = '0;
                pix_pos        = '0;
                col_num        = col_num + 1'b1;
                if (last) begin
                    frame_open = 1'b0;
                    return 1'b1;
                end
            end else begin
                pix_pos = pix_pos + 1'b1;
            end
        end
        row_pos = row_pos + 1'b1;
        if (row_pos >= row_pitch) begin
            row_pos   = '0;
            pix_pos   = '0;
            pix_bytes = '0;
            col_num   = '0;
            row_num   = row_num + 1'b1;
            if (row_num >= h) begin
                frame_open = 1'b0;
                row_num    = '0;
            end
        end
        return has;
    endfunction

    // Waits until every pending result is out, then lets trailing bytes drain.
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (status_pixel_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx sel, logic [12:0] val);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        write_shadow(sel, val);
    endtask

    task automatic send_item(logic func, logic [31:0] chunk, logic [7:0] data,
                             bit fixed, t_status st);
        t_result res;
        bit      has;
        if (!quiet && $urandom_range(99) < 26) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.func        <= func;
        in_ch.chunk_bytes <= chunk;
        in_ch.data_byte   <= data;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        has = convert_item(func, chunk, data, res);
        if (has && fixed) begin
            res        = '0;
            res.kind   = KIND_STATUS;
            res.status = st;
        end
        if (has) status_pixel_q.push_back(res);
        counted++;
    endtask

    task automatic randomise_regs();
        int r;
        r = $urandom_range(99);
        write_reg(CFG_WIDTH, (r < 6) ? 13'd0 : 13'($urandom_range(1, 9)));
        r = $urandom_range(99);
        write_reg(CFG_HEIGHT, (r < 6) ? 13'd0 : 13'($urandom_range(1, 5)));
        r = $urandom_range(99);
        if (r < 40)
            write_reg(CFG_BPP, {5'($urandom), DEPTH_24});
        else if (r < 80)
            write_reg(CFG_BPP, {5'($urandom), DEPTH_32});
        else
            write_reg(CFG_BPP, 13'($urandom_range(0, 8191)));
        write_reg(CFG_BOTTOM_UP, 13'($urandom));
    endtask

    function automatic t_step cfg_step(t_cfg_idx sel, logic [12:0] val);
        t_step s;
        s         = '0;
        s.op      = OP_CFG;
        s.reg_sel = sel;
        s.value   = 32'(val);
        return s;
    endfunction

    function automatic t_step start_step(logic [31:0] chunk, t_status st);
        t_step s;
        s        = '0;
        s.op     = OP_START;
        s.value  = chunk;
        s.fixed  = 1'b1;
        s.status = st;
        return s;
    endfunction

    function automatic t_step byte_step(logic [7:0] data);
        t_step s;
        s       = '0;
        s.op    = OP_BYTE;
        s.value = 32'(data);
        return s;
    endfunction

    // Result side: checks each transaction and decides ready for the next edge.
    initial begin
        t_result want;
        int      hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                if (status_pixel_q.size() == 0) begin
                    report_mismatch("result with nothing pending", 32'(out_ch.dest_index),
                                    32'd0);
                end else begin
                    want = status_pixel_q.pop_front();
                    if (out_ch.kind !== want.kind)
                        report_mismatch("kind", 32'(out_ch.kind), 32'(want.kind));
                    if (out_ch.status !== want.status)
                        report_mismatch("status", 32'(out_ch.status), 32'(want.status));
                    if (out_ch.pixel_bgra !== want.pixel_bgra)
                        report_mismatch("pixel_bgra", out_ch.pixel_bgra, want.pixel_bgra);
                    if (out_ch.dest_index !== want.dest_index)
                        report_mismatch("dest_index", 32'(out_ch.dest_index),
                                        32'(want.dest_index));
                    if (out_ch.frame_done !== want.frame_done)
                        report_mismatch("frame_done", 32'(out_ch.frame_done),
                                        32'(want.frame_done));
                end
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= quiet || ($urandom_range(99) >= 34);
            end
        end
    end

    initial begin
        t_step           steps [$];
        int              n_bytes;
        int              frame_no;
        int              mode;
        longint unsigned need;
        logic [31:0]     chunk;
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_index       <= CFG_WIDTH;
        i_cfg_data        <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.func        <= FUNC_START;
        in_ch.chunk_bytes <= '0;
        in_ch.data_byte   <= '0;
        out_ch.ready      <= 1'b0;
        cfg_width     = 13'd640;
        cfg_height    = 13'd480;
        cfg_depth     = DEPTH_24;
        cfg_bottom_up = 1'b1;
        frame_open    = 1'b0;
        row_pos       = '0;
        pix_pos       = '0;
        pix_bytes     = '0;
        row_num       = '0;
        row_pitch     = '0;
        col_num       = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset geometry is 640 x 480 at 24 bits, so a frame needs 921600 bytes.
        steps = {
            start_step(32'd0, STAT_TOO_SMALL),
            start_step(32'hFFFF_FFFF, STAT_OK),
            byte_step(8'h00), byte_step(8'hFF), byte_step(8'hA5),
            start_step(32'd921599, STAT_TOO_SMALL),
            start_step(32'd921600, STAT_OK),
            byte_step(8'h5A),
            // A register write drops the open frame, so the next byte is ignored.
            cfg_step(CFG_BOTTOM_UP, 13'h1FFE),
            byte_step(8'h34),
            cfg_step(CFG_BPP, 13'h1F20),
            cfg_step(CFG_WIDTH, 13'd0),
            cfg_step(CFG_HEIGHT, 13'h1FFF),
            start_step(32'd16384, STAT_OK),
            byte_step(8'h11), byte_step(8'h22), byte_step(8'h33), byte_step(8'h44),
            cfg_step(CFG_BOTTOM_UP, 13'd1),
            cfg_step(CFG_WIDTH, 13'h1FFF),
            cfg_step(CFG_HEIGHT, 13'd4096),
            cfg_step(CFG_BPP, 13'd24),
            start_step(32'hFFFF_FFFF, STAT_OK),
            byte_step(8'h80), byte_step(8'h7F), byte_step(8'h01),
            cfg_step(CFG_BPP, 13'd7),
            start_step(32'd0, STAT_BAD_DEPTH),
            cfg_step(CFG_BPP, 13'd255),
            start_step(32'hFFFF_FFFF, STAT_BAD_DEPTH),
            start_step(32'd5, STAT_TOO_SMALL)
        };
        foreach (steps[k]) begin
            case (steps[k].op)
                OP_CFG:   write_reg(steps[k].reg_sel, steps[k].value[12:0]);
                OP_START: send_item(FUNC_START, steps[k].value, 8'($urandom), 1'b1,
                                    steps[k].status);
                default:  send_item(FUNC_DATA, $urandom, steps[k].value[7:0], 1'b0, STAT_OK);
            endcase
        end

        counted  = 0;
        frame_no = 0;
        while (counted < RANDOM_ITEMS) begin
            quiet = (frame_no >= 6 && frame_no < 10);
            if (frame_no == 2 || frame_no == 12) begin
                // A wide frame while the result side is held off fills the block up.
                write_reg(CFG_WIDTH, 13'd40);
                write_reg(CFG_HEIGHT, 13'd3);
                write_reg(CFG_BPP, 13'(DEPTH_24));
                hold_req = 1'b1;
                mode     = 0;
            end else begin
                if (frame_no == 0 || $urandom_range(2) == 0)
                    randomise_regs();
                else if ($urandom_range(3) == 0)
                    settle();
                mode = $urandom_range(99);
            end
            need = expected_bytes();
            if (mode < 70) begin
                chunk   = 32'(need) + (($urandom_range(3) == 0) ? $urandom_range(0, 64) : 0);
                n_bytes = int'(need) + $urandom_range(0, 3);
            end else if (mode < 80) begin
                chunk   = (need == 0) ? $urandom : $urandom_range(0, int'(need) - 1);
                n_bytes = $urandom_range(0, 3);
            end else if (mode < 90) begin
                chunk   = 32'(need) + $urandom_range(0, 1000);
                n_bytes = $urandom_range(0, int'(need));
            end else begin
                chunk   = $urandom;
                n_bytes = $urandom_range(0, 24);
            end
            send_item(FUNC_START, chunk, 8'($urandom), 1'b0, STAT_OK);
            repeat (n_bytes) begin
                if (counted < RANDOM_ITEMS)
                    send_item(FUNC_DATA, $urandom, 8'($urandom), 1'b0, STAT_OK);
            end
            frame_no++;
        end
        quiet = 1'b0;

        settle();
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* raw_bitmap_to_bgra_unpack.f */
sv/rbu_pkg.sv
sv/rbu_in_if.sv
sv/rbu_out_if.sv
sv/rbu_ctrl.sv
sv/rbu_dp.sv
sv/rbu_outq.sv
sv/raw_bitmap_to_bgra_unpack.sv
bench/raw_bitmap_to_bgra_unpack_tb.sv
